/* hw/rtl/adcseg_pkg.sv */
package adcseg_pkg;

	// Field and register widths
	localparam int SampleW    = 12;
	localparam int SampleBits = 12;
	localparam int GainW      = 17;
	localparam int OffsetW    = 24;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 24;
	localparam int SegW       = 8;
	localparam int PosW       = 2;
	localparam int DigitW     = 4;
	localparam int NumDigits  = 4;

	// Scaling arithmetic
	localparam int FracBits = 16;
	localparam int ProdW    = SampleBits + GainW;
	localparam int ScaledW  = ProdW - FracBits;
	localparam int ValueW   = 14;
	localparam int CmpW     = (ScaledW > ValueW) ? ScaledW : ValueW;
	localparam int MaxValue = 9999;

	// Reciprocal of ten for values below 16384: floor(v * 6554 / 65536)
	localparam int RecipW     = 13;
	localparam int RecipTen   = 6554;
	localparam int RecipShift = 16;
	localparam int RecipProdW = ValueW + RecipW;

	// Register reset values
	localparam logic [GainW-1:0]   GainReset   = GainW'(62312);
	localparam logic [OffsetW-1:0] OffsetReset = OffsetW'(2700945);

	typedef enum logic [CfgIndexW-1:0] {
		REG_GAIN   = CfgIndexW'(0),
		REG_OFFSET = CfgIndexW'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [ValueW-1:0] quot;
		logic [DigitW-1:0] rem;
	} div10_t;

	// Split off the lowest decimal digit
	function automatic div10_t div10(input logic [ValueW-1:0] v);
		logic [RecipProdW-1:0] p;
		logic [ValueW-1:0]     q;
		logic [ValueW-1:0]     q10;
		div10_t                r;
		p = RecipProdW'(v) * RecipProdW'(RecipTen);
		q = ValueW'(p >> RecipShift);
		q10 = (q << 3) + (q << 1);
		r.quot = q;
		r.rem = DigitW'(v - q10);
		return r;
	endfunction

	// Segment pattern of one digit, bit 7 is segment a
	function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
		logic [SegW-1:0] s;
		unique case (d)
			4'd0: s = 8'hFC;
			4'd1: s = 8'h60;
			4'd2: s = 8'hDA;
			4'd3: s = 8'hF2;
			4'd4: s = 8'h66;
			4'd5: s = 8'hB6;
			4'd6: s = 8'hBE;
			4'd7: s = 8'hE0;
			4'd8: s = 8'hFE;
			4'd9: s = 8'hE6;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/adcseg_if.sv */
interface adcseg_sample_if
	import adcseg_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [SampleW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface adcseg_digit_if
	import adcseg_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [SegW-1:0] segments;
	logic [PosW-1:0] digit_position;
	logic            last;

	modport source (output valid, output segments, output digit_position, output last,
		input ready);
	modport sink (input valid, input segments, input digit_position, input last,
		output ready);
endinterface

/* hw/rtl/adcseg_digit_ser.sv */
module adcseg_digit_ser
	import adcseg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_valid,
	output logic              ld_ready,
	input  logic [ValueW-1:0] ld_value,
	adcseg_digit_if.source    digits
);

	logic              busy_q;
	logic [PosW-1:0]   pos_q;
	logic              last_q;
	logic [SegW-1:0]   seg_q;
	logic [ValueW-1:0] rest_q;

	logic              free;
	logic              step;
	logic              load;
	logic [ValueW-1:0] src;
	div10_t            dv;
	logic [PosW-1:0]   pos_next;

	// Free when empty or when the thousands transaction completes
	assign free     = !busy_q || (digits.ready && last_q);
	assign step     = busy_q && digits.ready && !last_q;
	assign load     = ld_valid && free;
	assign ld_ready = free;

	// Peel one decimal digit per transaction
	assign src      = step ? rest_q : ld_value;
	assign dv       = div10(src);
	assign pos_next = pos_q + PosW'(1);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			last_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_next;
			last_q <= (pos_next == PosW'(NumDigits - 1));
		end else if (free) begin
			busy_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load || step) begin
			seg_q  <= seg_pattern(dv.rem);
			rest_q <= dv.quot;
		end
	end

	assign digits.valid          = busy_q;
	assign digits.segments       = seg_q;
	assign digits.digit_position = pos_q;
	assign digits.last           = last_q;

endmodule

/* hw/rtl/adc_average_to_seven_segment_digits.sv */
// Running-average ADC readout for a four-digit seven-segment display.
// Channels: samples (valid/ready, one ADC sample per transaction) and
// digits (valid/ready, one segment byte per transaction with its digit
// position and a last flag). Configuration: cfg_we/cfg_index/cfg_wdata
// write the gain (index 0) and offset (index 1) in Q16; other indexes
// are ignored. Write them only while the block is idle.
// Each sample updates the running average, is scaled, clamped to
// 0..9999 and leaves as four transactions: ones, tens, hundreds, then
// thousands with last set.
// The ones digit passes the average, product and value stages and the
// serializer output register before it is presented.
// The single digit channel carries four transactions per sample and so
// sets the sample rate; a three-stage pipeline in front of the digit
// serializer takes samples every cycle until it fills.
// Reset clears the average to 0, loads the default gain and offset and
// empties the pipeline. When the receiver stalls, the current digit is
// held, the pipeline fills, and then samples.ready drops.
module adc_average_to_seven_segment_digits
	import adcseg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	adcseg_sample_if.sink        samples,
	adcseg_digit_if.source       digits
);

	logic [GainW-1:0]      gain_q;
	logic [OffsetW-1:0]    offset_q;
	logic [SampleBits-1:0] avg_q;

	logic                  valid_s1;
	logic [SampleBits-1:0] avg_s1;
	logic                  valid_s2;
	logic [ProdW-1:0]      prod_s2;
	logic                  valid_s3;
	logic [ValueW-1:0]     value_s3;

	logic                  ld_ready;
	logic                  take1;
	logic                  take2;
	logic                  take3;
	logic                  in_acc;
	logic [SampleBits-1:0] sample_m;
	logic [SampleBits:0]   avg_sum;
	logic [SampleBits-1:0] avg_next;
	logic [ProdW-1:0]      offset_ext;
	logic [ProdW-1:0]      diff;
	logic [ScaledW-1:0]    scaled;
	logic [ValueW-1:0]     value_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GainReset;
			offset_q <= OffsetReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN:   gain_q   <= GainW'(cfg_wdata);
				REG_OFFSET: offset_q <= OffsetW'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Stall chain: a stage takes new data when empty or when it moves on
	assign take3         = !valid_s3 || ld_ready;
	assign take2         = !valid_s2 || take3;
	assign take1         = !valid_s1 || take2;
	assign samples.ready = take1;
	assign in_acc        = samples.valid && take1;

	// Running average update
	assign sample_m = SampleBits'(samples.sample);
	assign avg_sum  = {1'b0, sample_m} + {1'b0, avg_q};
	assign avg_next = avg_sum[SampleBits:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (in_acc) begin
			avg_q <= avg_next;
		end
	end

	// Subtract offset, drop the fraction, clamp to the display range
	assign offset_ext = ProdW'(offset_q);
	assign diff       = prod_s2 - offset_ext;
	assign scaled     = diff[ProdW-1:FracBits];

	always_comb begin
		if (prod_s2 < offset_ext) begin
			value_next = '0;
		end else if (CmpW'(scaled) > CmpW'(MaxValue)) begin
			value_next = ValueW'(MaxValue);
		end else begin
			value_next = ValueW'(scaled);
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (take1) valid_s1 <= in_acc;
			if (take2) valid_s2 <= valid_s1;
			if (take3) valid_s3 <= valid_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (in_acc) avg_s1 <= avg_next;
		if (take2 && valid_s1) prod_s2 <= ProdW'(avg_s1) * ProdW'(gain_q);
		if (take3 && valid_s2) value_s3 <= value_next;
	end

	// Digit serializer and output register
	adcseg_digit_ser u_digit_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (valid_s3),
		.ld_ready (ld_ready),
		.ld_value (value_s3),
		.digits   (digits)
	);

endmodule

/* test/adc_average_to_seven_segment_digits_test.sv */
`timescale 1ns / 1ps

module adc_average_to_seven_segment_digits_test;
	import adcseg_pkg::*;

	// Config indexes past the register list; writes there must be dropped
	localparam logic [CfgIndexW-1:0] REG_UNUSED_A = CfgIndexW'(2);
	localparam logic [CfgIndexW-1:0] REG_UNUSED_B = CfgIndexW'(3);
	localparam int MaxReports = 50;

	typedef struct packed {
		logic [SegW-1:0] segments;
		logic [PosW-1:0] position;
		logic            last;
	} digit_t;

	// Running average, Q16 scaling and digit split; holds the digits still due
	class segment_scoreboard;
		logic [GainW-1:0]      gain;
		logic [OffsetW-1:0]    offset;
		logic [SampleBits-1:0] avg;
		logic [SegW-1:0]       seg_code [10];
		digit_t                pending_digits [$];

		function new();
			gain = GainReset;
			offset = OffsetReset;
			avg = '0;
			seg_code = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hE6};
		endfunction

		function void write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
			if (idx == REG_GAIN)
				gain = data[GainW-1:0];
			else if (idx == REG_OFFSET)
				offset = data[OffsetW-1:0];
		endfunction

		function void note_sample(input logic [SampleW-1:0] raw);
			logic [SampleBits:0] total;
			logic [63:0]         product;
			logic [63:0]         scaled;
			int unsigned         value;
			digit_t              d;
			total = {1'b0, raw[SampleBits-1:0]} + {1'b0, avg};
			avg = total[SampleBits:1];
			product = 64'(avg) * 64'(gain);
			// Clamp below zero, saturate above four digits
			if (product < 64'(offset)) begin
				value = 0;
			end else begin
				scaled = (product - 64'(offset)) >> FracBits;
				value = (scaled > 64'(MaxValue)) ? MaxValue : int'(scaled);
			end
			for (int p = 0; p < NumDigits; p++) begin
				d.segments = seg_code[value % 10];
				d.position = PosW'(p);
				d.last = (p == NumDigits - 1);
				pending_digits.push_back(d);
				value = value / 10;
			end
		endfunction

		// Return an empty string on a match, else what differed
		function string check_digit(input digit_t got);
			digit_t want;
			string  msg;
			if (pending_digits.size() == 0)
				return $sformatf("digit seg=%02h pos=%0d last=%0b with none pending",
					got.segments, got.position, got.last);
			want = pending_digits.pop_front();
			msg = "";
			if (got.segments !== want.segments)
				msg = {msg, $sformatf(" segments got %02h want %02h", got.segments, want.segments)};
			if (got.position !== want.position)
				msg = {msg, $sformatf(" position got %0d want %0d", got.position, want.position)};
			if (got.last !== want.last)
				msg = {msg, $sformatf(" last got %0b want %0b", got.last, want.last)};
			return msg;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_wdata;
	logic                 calm;
	int                   mismatches;
	segment_scoreboard    board;

	adcseg_sample_if samples_if ();
	adcseg_digit_if  digits_if ();

	adc_average_to_seven_segment_digits u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_if.sink),
		.digits    (digits_if.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up after a generous bound
	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MaxReports)
			$display("MISMATCH at %0t:%s", $time, msg);
		mismatches++;
	endtask

	// Stall the digit receiver in random bursts
	initial begin
		int stall;
		stall = 0;
		digits_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				digits_if.ready = 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				digits_if.ready = 1'b0;
				stall = $urandom_range(0, 7);
			end else begin
				digits_if.ready = 1'b1;
			end
		end
	end

	// Check every digit transaction against the oldest pending digit
	always @(posedge clk) begin
		string  msg;
		digit_t got;
		if (arst_n && digits_if.valid && digits_if.ready) begin
			got.segments = digits_if.segments;
			got.position = digits_if.digit_position;
			got.last = digits_if.last;
			msg = board.check_digit(got);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.write_reg(idx, data);
	endtask

	// Hold one sample until the block takes it, with an optional gap first
	task automatic send_sample(input logic [SampleW-1:0] value);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			samples_if.valid = 1'b0;
			samples_if.sample = SampleW'($urandom);
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.sample = value;
		do
			@(posedge clk);
		while (!samples_if.ready);
		board.note_sample(value);
	endtask

	// Stop sending and wait until every pending digit is out
	task automatic drain();
		@(negedge clk);
		samples_if.valid = 1'b0;
		while (board.pending_digits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [SampleW-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SampleW'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		board = new();
		mismatches = 0;
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset gain and offset: clamp at zero, ramp to full scale, bit patterns
		send_sample(12'h000);
		repeat (4) send_sample(12'hFFF);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(12'h001);
		send_sample(12'hFFE);
		send_sample(12'h800);
		drain();

		// Largest gain with extra data bits masked off, no offset
		write_reg(REG_GAIN, 24'hFFFFFF);
		write_reg(REG_OFFSET, 24'h000000);
		repeat (3) send_sample(12'hFFF);
		send_sample(12'h000);
		drain();

		// Writes past the register list are dropped; zero gain gives zero
		write_reg(REG_UNUSED_A, 24'h012345);
		write_reg(REG_UNUSED_B, 24'hFFFFFF);
		write_reg(REG_GAIN, 24'h000000);
		send_sample(12'hFFF);
		send_sample(12'h07B);
		drain();

		// Unit gain against the largest offset
		write_reg(REG_GAIN, 24'h010000);
		write_reg(REG_OFFSET, 24'hFFFFFF);
		send_sample(12'hFFF);
		send_sample(12'hFFF);
		send_sample(12'h000);
		drain();

		// Random phases, each with its own setting
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_GAIN, CfgDataW'(GainReset));
					write_reg(REG_OFFSET, CfgDataW'(OffsetReset));
				end
				2: begin
					write_reg(REG_GAIN, CfgDataW'(17'h1FFFF));
					write_reg(REG_OFFSET, CfgDataW'($urandom_range(0, 65535)));
				end
				default: begin
					write_reg(REG_GAIN, CfgDataW'($urandom));
					write_reg(REG_OFFSET, CfgDataW'($urandom_range(0, 24'h3FFFFF)));
				end
			endcase
			calm = (ph == 3);
			repeat (16) send_sample(random_sample());
			drain();
		end

		// Last stretch with no idling on either side
		calm = 1'b1;
		write_reg(REG_GAIN, CfgDataW'($urandom_range(40000, 131071)));
		write_reg(REG_OFFSET, CfgDataW'($urandom_range(0, 24'hFFFFFF)));
		repeat (15) send_sample(random_sample());
		drain();
		repeat (12) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/adcseg_pkg.sv
hw/rtl/adcseg_if.sv
hw/rtl/adcseg_digit_ser.sv
hw/rtl/adc_average_to_seven_segment_digits.sv
test/adc_average_to_seven_segment_digits_test.sv
